// ===== rtl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge of clk outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold at the same edge.
`define ASSERT_IMPLY(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pkr_pkg.sv =====
// ============================================================================
// Septet packer package
// Widths, constants and the structs passed between the packer stages.
// ============================================================================
`default_nettype none

package pkr_pkg;

    localparam int SEPTET_W = 7;
    localparam int OCTET_W  = 8;
    localparam int FILL_W   = 3;
    localparam int BUF_W    = 2 * SEPTET_W;

    // Largest fill honored; a value of seven is saturated to this.
    localparam logic [FILL_W-1:0] FILL_MAX = 3'd6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // The front may push two words, so it is let in only while the queue
    // holds at most this many words.
    localparam logic [QCNT_W-1:0] QUEUE_ROOM_MAX = QCNT_W'(QUEUE_DEPTH - 2);

    typedef struct packed {
        logic [OCTET_W-1:0] octet;
        logic               last_octet;
    } word_t;

    // Words pushed by the front in one cycle; word0 is the older one.
    typedef struct packed {
        logic [1:0] count;
        word_t      word0;
        word_t      word1;
    } push_t;

    // Head of the queue as seen by the output stage.
    typedef struct packed {
        logic  valid;
        word_t word;
    } head_t;

endpackage

`default_nettype wire

// ===== rtl/pkr_if.sv =====
// ============================================================================
// Septet packer channel interfaces
// Valid/ready channels for septets in, octets out and the fill register.
// ============================================================================
`default_nettype none

interface pkr_in_if;
    logic       valid;
    logic       ready;
    logic [6:0] septet;
    logic       last_septet;

    modport source (output valid, output septet, output last_septet, input ready);
    modport sink   (input valid, input septet, input last_septet, output ready);
endinterface

interface pkr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] octet;
    logic       last_octet;

    modport source (output valid, output octet, output last_octet, input ready);
    modport sink   (input valid, input octet, input last_octet, output ready);
endinterface

interface pkr_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] fill_bits;

    modport source (output valid, output fill_bits, input ready);
    modport sink   (input valid, input fill_bits, output ready);
endinterface

`default_nettype wire

// ===== rtl/pkr_front.sv =====
// ============================================================================
// Septet packer front end
// Accepts septets, merges them into the bit buffer and pushes finished words.
// ============================================================================
`default_nettype none

module pkr_front (
    input  wire logic    clk,
    input  wire logic    rst_n,
    pkr_in_if.sink       septets,
    pkr_cfg_if.sink      cfg,
    input  wire logic    room,
    output pkr_pkg::push_t push
);
    import pkr_pkg::*;

    logic [FILL_W-1:0]   fill_reg;
    logic [SEPTET_W-1:0] buf_reg, buf_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic                start_reg, start_next;

    logic                accept;
    logic [FILL_W-1:0]   fill_sat;
    logic [2:0]          base_cnt;
    logic [SEPTET_W-1:0] base_buf;
    logic [BUF_W-1:0]    merged;
    logic [3:0]          total;
    logic                full;
    logic [SEPTET_W-1:0] rem_buf;
    logic [2:0]          rem_cnt;
    logic                flush;
    word_t               full_word;
    word_t               flush_word;

    assign cfg.ready     = 1'b1;
    assign septets.ready = room;
    assign accept        = septets.valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cfg.valid)
        begin
            fill_reg <= cfg.fill_bits;
        end
    end

    always_comb
    begin
        fill_sat = (fill_reg > FILL_MAX) ? FILL_MAX : fill_reg;
        base_cnt = start_reg ? fill_sat : cnt_reg;
        base_buf = start_reg ? '0 : buf_reg;
        merged   = {{SEPTET_W{1'b0}}, base_buf}
                 | ({{SEPTET_W{1'b0}}, septets.septet} << base_cnt);
        total    = {1'b0, base_cnt} + 4'd7;
        // The total is 7 to 14, so bit 3 alone tells whether an octet is full.
        full     = total[3];
        rem_cnt  = total[2:0];
        rem_buf  = full ? {1'b0, merged[BUF_W-1:OCTET_W]} : merged[SEPTET_W-1:0];
        flush    = septets.last_septet && (rem_cnt != 3'd0);

        full_word.octet       = merged[OCTET_W-1:0];
        full_word.last_octet  = septets.last_septet && !flush;
        flush_word.octet      = {1'b0, rem_buf};
        flush_word.last_octet = 1'b1;
    end

    always_comb
    begin
        push.count = 2'd0;
        push.word0 = full_word;
        push.word1 = flush_word;
        if (accept)
        begin
            priority if (full && flush)
            begin
                push.count = 2'd2;
            end
            else if (full)
            begin
                push.count = 2'd1;
            end
            else if (flush)
            begin
                push.count = 2'd1;
                push.word0 = flush_word;
            end
        end
    end

    always_comb
    begin
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        start_next = start_reg;
        if (accept)
        begin
            if (septets.last_septet)
            begin
                buf_next   = '0;
                cnt_next   = 3'd0;
                start_next = 1'b1;
            end
            else
            begin
                buf_next   = rem_buf;
                cnt_next   = rem_cnt;
                start_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= '0;
            cnt_reg   <= 3'd0;
            start_reg <= 1'b1;
        end
        else
        begin
            buf_reg   <= buf_next;
            cnt_reg   <= cnt_next;
            start_reg <= start_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pkr_queue.sv =====
// ============================================================================
// Septet packer word queue
// Four-slot queue taking up to two words a cycle and giving one.
// ============================================================================
`default_nettype none

module pkr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pkr_pkg::push_t push,
    output logic                room,
    output pkr_pkg::head_t      head,
    input  wire logic           pop
);
    import pkr_pkg::*;

    word_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_1;

    assign wr_ptr_1   = wr_ptr_reg + QPTR_W'(1);
    assign room       = (count_reg <= QUEUE_ROOM_MAX);
    assign head.valid = (count_reg != '0);
    assign head.word  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push.word0;
        end
        if (push.count == 2'd2)
        begin
            slot_reg[wr_ptr_1] <= push.word1;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pkr_back.sv =====
// ============================================================================
// Septet packer output stage
// Moves words from the queue head into the registered output channel.
// ============================================================================
`default_nettype none

module pkr_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pkr_pkg::head_t head,
    output logic                pop,
    pkr_out_if.source           octets
);
    import pkr_pkg::*;

    logic  valid_reg, valid_next;
    word_t word_reg;

    // A valid head refills the register when empty or when its word is taken.
    assign pop = head.valid && (!valid_reg || octets.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (octets.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg <= head.word;
        end
    end

    assign octets.valid      = valid_reg;
    assign octets.octet      = word_reg.octet;
    assign octets.last_octet = word_reg.last_octet;

endmodule

`default_nettype wire

// ===== rtl/septet_to_octet_packer.sv =====
// ============================================================================
// Septet to octet packer
// Packs 7-bit characters into lsb-first octets with leading fill and flush.
// ============================================================================
//
//  Channel   Dir   Payload                  Handshake
//  septets   in    septet, last_septet      valid / ready
//  octets    out   octet, last_octet        valid / ready
//  cfg       in    fill_bits                valid / ready (ready always high)
//
//  One septet is taken per cycle while the four-word queue has two free slots.
//  Each word is written into a queue slot and then into the output register, from which it leaves.
//  Reset clears the bit buffer, the queue and the fill register; no sweep is run.
//  A stalled output fills the queue, and then septets wait at the input.
//
`default_nettype none
`include "assert_macros.svh"

module septet_to_octet_packer (
    input  wire logic clk,
    input  wire logic rst_n,
    pkr_in_if.sink    septets,
    pkr_out_if.source octets,
    pkr_cfg_if.sink   cfg
);
    import pkr_pkg::*;

    push_t push;
    head_t head;
    logic  room;
    logic  pop;

    pkr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .septets (septets),
        .cfg     (cfg),
        .room    (room),
        .push    (push)
    );

    pkr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .head  (head),
        .pop   (pop)
    );

    pkr_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .octets (octets)
    );

    `ASSERT_IMPLY(a_pop_needs_word, pop, head.valid, "pop from an empty queue")
    `ASSERT_IMPLY(a_push_needs_accept, push.count != 2'd0,
                  septets.valid && septets.ready, "push without an accepted septet")
    `ASSERT_IMPLY(a_pair_ends_message, push.count == 2'd2,
                  push.word1.last_octet && !push.word0.last_octet,
                  "two-word push not ending a message")
    `ASSERT_IMPLY(a_last_gives_word,
                  septets.valid && septets.ready && septets.last_septet,
                  push.count != 2'd0, "last septet pushed no word")
    `ASSERT_ALWAYS(a_push_count_range, push.count != 2'd3, "push count out of range")

endmodule

`default_nettype wire
